>>> sv/ufd_pkg.sv
// shared types and constants for the uart frame deframer
// used by every module of the block, depends on nothing
package ufd_pkg;

  // largest data length a frame may carry
  localparam int MAX_DATA_LEN = 8;
  localparam int LEN_W        = $clog2(MAX_DATA_LEN + 1);
  localparam int IDX_W        = $clog2(MAX_DATA_LEN);
  localparam int IDLE_W       = 17;
  localparam int QUEUE_DEPTH  = 2;

  // register reset values
  localparam logic [7:0]  START_RST   = 8'd170;
  localparam logic [7:0]  END_RST     = 8'd85;
  localparam logic [3:0]  MAX_LEN_RST = 4'd8;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  // register indexes on the config port
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_END     = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  // input item kinds carried on tuser
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_WAIT = 3'd0,
    ST_ID   = 3'd1,
    ST_SEQ  = 3'd2,
    ST_LEN  = 3'd3,
    ST_DATA = 3'd4,
    ST_CRC  = 3'd5,
    ST_END  = 3'd6
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [3:0]  max_len;
    logic [15:0] timeout_ms;
  } cfg_t;

  // one completed frame as handed from the parser to the emitter
  typedef struct packed {
    logic [7:0]                        msg_id;
    logic [7:0]                        seq_num;
    logic [LEN_W-1:0]                  data_len;
    logic [7:0]                        crc_byte;
    logic [MAX_DATA_LEN-1:0][7:0]      data;
  } frame_t;

endpackage

>>> sv/ufd_cfg.sv
// configuration registers behind the apb-style port
// depends on ufd_pkg for the register map and cfg_t
module ufd_cfg import ufd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes, low address bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_RST;
      cfg.end_byte   <= END_RST;
      cfg.max_len    <= MAX_LEN_RST;
      cfg.timeout_ms <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_START:   cfg.start_byte <= pwdata[7:0];
        REG_END:     cfg.end_byte   <= pwdata[7:0];
        REG_MAX_LEN: cfg.max_len    <= pwdata[3:0];
        REG_TIMEOUT: cfg.timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_START:   prdata = {24'd0, cfg.start_byte};
      REG_END:     prdata = {24'd0, cfg.end_byte};
      REG_MAX_LEN: prdata = {28'd0, cfg.max_len};
      REG_TIMEOUT: prdata = {16'd0, cfg.timeout_ms};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/ufd_front.sv
// frame parser: takes bytes and ticks, tracks idle time, builds frames
// depends on ufd_pkg; pushes finished frames into ufd_queue
module ufd_front import ufd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output frame_t     q_frame
);

  parse_state_t state, state_next, eff_state;
  logic [IDLE_W-1:0]  idle_count;
  logic [7:0]         id_hold, seq_hold, crc_hold;
  logic [LEN_W-1:0]   len_hold;
  logic [IDX_W-1:0]   wr_pos;
  logic [MAX_DATA_LEN-1:0][7:0] data_store;
  logic               byte_acc, tick_acc, len_ok, data_done;
  logic               ld_id, ld_seq, ld_len, ld_data, ld_crc;

  assign in_ready = !q_full;
  assign byte_acc = in_valid && in_ready && (in_kind == REQ_BYTE);
  assign tick_acc = in_valid && in_ready && (in_kind == REQ_TICK);

  // a late byte first drops any partial frame
  assign eff_state = (idle_count > {1'b0, cfg.timeout_ms}) ? ST_WAIT : state;

  assign len_ok = (in_byte != 8'd0) && (in_byte <= {4'd0, cfg.max_len})
                  && (in_byte <= 8'(MAX_DATA_LEN));
  assign data_done = ({1'b0, wr_pos} + LEN_W'(1)) == len_hold;

  // next state
  always_comb begin
    state_next = state;
    if (byte_acc) begin
      case (eff_state)
        ST_WAIT: state_next = (in_byte == cfg.start_byte) ? ST_ID : ST_WAIT;
        ST_ID:   state_next = ST_SEQ;
        ST_SEQ:  state_next = ST_LEN;
        ST_LEN:  state_next = len_ok ? ST_DATA : ST_WAIT;
        ST_DATA: state_next = data_done ? ST_CRC : ST_DATA;
        ST_CRC:  state_next = ST_END;
        ST_END:  state_next = ST_WAIT;
        default: state_next = ST_WAIT;
      endcase
    end
  end

  // per-state load strobes
  always_comb begin
    ld_id   = 1'b0;
    ld_seq  = 1'b0;
    ld_len  = 1'b0;
    ld_data = 1'b0;
    ld_crc  = 1'b0;
    q_push  = 1'b0;
    if (byte_acc) begin
      case (eff_state)
        ST_ID:   ld_id   = 1'b1;
        ST_SEQ:  ld_seq  = 1'b1;
        ST_LEN:  ld_len  = len_ok;
        ST_DATA: ld_data = 1'b1;
        ST_CRC:  ld_crc  = 1'b1;
        ST_END:  q_push  = (in_byte == cfg.end_byte);
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WAIT;
      idle_count <= '0;
      wr_pos     <= '0;
    end else begin
      state <= state_next;
      if (byte_acc) begin
        idle_count <= '0;
      end else if (tick_acc && (idle_count != '1)) begin
        idle_count <= idle_count + IDLE_W'(1);
      end
      if (ld_len) begin
        wr_pos <= '0;
      end else if (ld_data) begin
        wr_pos <= wr_pos + IDX_W'(1);
      end
    end
  end

  // header holds
  always_ff @(posedge clk) begin
    if (rst) begin
      id_hold  <= '0;
      seq_hold <= '0;
      len_hold <= '0;
      crc_hold <= '0;
    end else begin
      if (ld_id)  id_hold  <= in_byte;
      if (ld_seq) seq_hold <= in_byte;
      if (ld_len) len_hold <= in_byte[LEN_W-1:0];
      if (ld_crc) crc_hold <= in_byte;
    end
  end

  // data bytes, no reset
  always_ff @(posedge clk) begin
    if (ld_data) data_store[wr_pos] <= in_byte;
  end

  assign q_frame.msg_id   = id_hold;
  assign q_frame.seq_num  = seq_hold;
  assign q_frame.data_len = len_hold;
  assign q_frame.crc_byte = crc_hold;
  assign q_frame.data     = data_store;

endmodule

>>> sv/ufd_queue.sv
// short frame queue between parser and emitter
// depends on ufd_pkg for frame_t and QUEUE_DEPTH
module ufd_queue import ufd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output frame_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  frame_t               slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [PTR_W:0]       count;

  assign full      = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_frame;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("frame pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("frame popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

>>> sv/ufd_back.sv
// frame emitter: walks the head frame one data byte per result
// depends on ufd_pkg; reads ufd_queue head, drives the output register
module ufd_back import ufd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  frame_t     q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] msg_id,
  output logic [7:0] seq_num,
  output logic [3:0] data_len,
  output logic [2:0] data_index,
  output logic [7:0] data_byte,
  output logic [7:0] crc_byte,
  output logic       last
);

  logic [IDX_W-1:0] idx;
  logic             load, is_last;

  assign load    = q_valid && (!out_valid || out_ready);
  assign is_last = ({1'b0, idx} + LEN_W'(1)) == q_head.data_len;
  assign q_pop   = load && is_last;

  // result index within the head frame
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) idx <= is_last ? '0 : idx + IDX_W'(1);
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      msg_id     <= q_head.msg_id;
      seq_num    <= q_head.seq_num;
      data_len   <= 4'(q_head.data_len);
      data_index <= 3'(idx);
      data_byte  <= q_head.data[idx];
      crc_byte   <= q_head.crc_byte;
      last       <= is_last;
    end
  end

  a_index_in_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, data_index} < data_len))
    else $error("data index beyond frame length");
  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (({1'b0, data_index} + 4'd1) == data_len))
    else $error("last marked on wrong byte");
  a_pop_once: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (idx == '0)) else $error("index not rewound after frame");

endmodule

>>> sv/uart_frame_deframer.sv
// uart frame deframer top: parser, frame queue, emitter and config registers
// an input item (byte or tick) is taken while the queue has room; a matching end byte
// queues the frame and the emitter loads results into the output register, one
// result per cycle unless m_tready stalls; a two-frame queue lets the parser run ahead
// synchronous active-high reset returns the parser to waiting and empties queue
module uart_frame_deframer import ufd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] req_type
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] msg_id, [15:8] seq_num, [19:16] data_len,
                                 // [22:20] data_index, [30:23] data_byte,
                                 // [38:31] crc_byte, [39] zero
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  frame_t     push_frame, head;
  logic       q_push, q_pop, q_full, q_valid;
  logic [7:0] msg_id, seq_num, data_byte, crc_byte;
  logic [3:0] data_len;
  logic [2:0] data_index;

  ufd_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg(cfg)
  );

  ufd_front u_front (
    .clk, .rst, .cfg(cfg),
    .in_valid(s_tvalid), .in_kind(s_tuser), .in_byte(s_tdata), .in_ready(s_tready),
    .q_full(q_full), .q_push(q_push), .q_frame(push_frame)
  );

  ufd_queue u_queue (
    .clk, .rst, .push(q_push), .push_frame(push_frame), .pop(q_pop),
    .full(q_full), .not_empty(q_valid), .head(head)
  );

  ufd_back u_back (
    .clk, .rst, .q_valid(q_valid), .q_head(head), .q_pop(q_pop),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .msg_id(msg_id), .seq_num(seq_num), .data_len(data_len),
    .data_index(data_index), .data_byte(data_byte), .crc_byte(crc_byte),
    .last(m_tlast)
  );

  // pack result fields, lowest first
  assign m_tdata = {1'b0, crc_byte, data_byte, data_index, data_len, seq_num, msg_id};

endmodule

>>> verif/uart_frame_deframer_test.sv
// self-checking testbench for uart_frame_deframer: drives byte and tick items,
// writes the config registers over apb and checks every result item
// depends on ufd_pkg and the uart_frame_deframer rtl only
module uart_frame_deframer_test;
  import ufd_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 120;
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  // one expected result item
  typedef struct packed {
    logic [7:0]       msg_id;
    logic [7:0]       seq_num;
    logic [LEN_W-1:0] data_len;
    logic [IDX_W-1:0] data_index;
    logic [7:0]       data_byte;
    logic [7:0]       crc_byte;
    logic             is_last;
  } frame_beat_t;

  // frame parser copy plus the queue of result items it has predicted
  class frame_scoreboard;
    logic [7:0]        start_b;
    logic [7:0]        end_b;
    logic [3:0]        max_len;
    logic [15:0]       timeout_ms;
    parse_state_t      state;
    logic [7:0]        id_q;
    logic [7:0]        seq_q;
    logic [3:0]        len_q;
    logic [3:0]        left_q;
    logic [7:0]        crc_q;
    logic [7:0]        data_q [MAX_DATA_LEN];
    logic [IDLE_W-1:0] idle_ms;
    frame_beat_t       beats_due [$];
    int                errors;

    function new();
      start_b    = START_RST;
      end_b      = END_RST;
      max_len    = MAX_LEN_RST;
      timeout_ms = TIMEOUT_RST;
      state      = ST_WAIT;
      id_q       = '0;
      seq_q      = '0;
      len_q      = '0;
      left_q     = '0;
      crc_q      = '0;
      idle_ms    = '0;
      errors     = 0;
    endfunction

    // one line per mismatch
    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_START:   start_b    = v[7:0];
        REG_END:     end_b      = v[7:0];
        REG_MAX_LEN: max_len    = v[3:0];
        default:     timeout_ms = v[15:0];
      endcase
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    // advance the parser by one accepted input item
    function void take_item(logic kind, logic [7:0] b);
      int pos;
      int k;
      frame_beat_t beat;
      if (kind == REQ_TICK) begin
        if (idle_ms < IDLE_MAX) idle_ms++;
        return;
      end
      // a byte after too long a silence restarts the parser first
      if (idle_ms > timeout_ms) state = ST_WAIT;
      idle_ms = '0;
      case (state)
        ST_WAIT: if (b == start_b) state = ST_ID;
        ST_ID: begin
          id_q  = b;
          state = ST_SEQ;
        end
        ST_SEQ: begin
          seq_q = b;
          state = ST_LEN;
        end
        ST_LEN: begin
          if (b == 0 || b > max_len || b > MAX_DATA_LEN) begin
            state = ST_WAIT;
          end else begin
            len_q  = b[3:0];
            left_q = b[3:0];
            state  = ST_DATA;
          end
        end
        ST_DATA: begin
          pos = int'(len_q) - int'(left_q);
          if (left_q == 0 || left_q > len_q || pos >= MAX_DATA_LEN) begin
            state = ST_WAIT;
          end else begin
            data_q[pos] = b;
            left_q--;
            if (left_q == 0) state = ST_CRC;
          end
        end
        ST_CRC: begin
          crc_q = b;
          state = ST_END;
        end
        ST_END: begin
          // good end byte releases one result per data byte
          if (b == end_b) begin
            for (k = 0; k < len_q; k++) begin
              beat.msg_id     = id_q;
              beat.seq_num    = seq_q;
              beat.data_len   = len_q;
              beat.data_index = k[IDX_W-1:0];
              beat.data_byte  = data_q[k];
              beat.crc_byte   = crc_q;
              beat.is_last    = (k + 1 == len_q);
              beats_due.push_back(beat);
            end
          end
          state = ST_WAIT;
        end
        default: state = ST_WAIT;
      endcase
    endfunction

    // compare one accepted result item with the oldest prediction
    function void check_beat(logic [39:0] d, logic tl);
      frame_beat_t want;
      if (beats_due.size() == 0) begin
        report($sformatf("result %h with nothing expected", d));
        return;
      end
      want = beats_due.pop_front();
      if (d[7:0] !== want.msg_id)
        report($sformatf("msg_id %h, expected %h", d[7:0], want.msg_id));
      if (d[15:8] !== want.seq_num)
        report($sformatf("seq_num %h, expected %h", d[15:8], want.seq_num));
      if (d[19:16] !== want.data_len)
        report($sformatf("data_len %0d, expected %0d", d[19:16], want.data_len));
      if (d[22:20] !== want.data_index)
        report($sformatf("data_index %0d, expected %0d", d[22:20], want.data_index));
      if (d[30:23] !== want.data_byte)
        report($sformatf("data_byte %h, expected %h", d[30:23], want.data_byte));
      if (d[38:31] !== want.crc_byte)
        report($sformatf("crc_byte %h, expected %h", d[38:31], want.crc_byte));
      if (d[39] !== 1'b0)
        report($sformatf("pad bit %b, expected 0", d[39]));
      if (tl !== want.is_last)
        report($sformatf("tlast %b, expected %b", tl, want.is_last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  int              sent;
  bit              quiet_tail;
  bit              rx_hold_req;

  uart_frame_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result sink: random stalls, one long hold-off on request, none at the tail
  initial begin : result_sink
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
        m_tready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
  end

  // watchdog on cycles with no handshake anywhere
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("** uart_frame_deframer: FAILED **");
    $finish;
  end

  // offer one input item, with an occasional gap ahead of it
  task automatic send_item(input logic kind, input logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    sb.take_item(kind, b);
    sent++;
    @(negedge clk);
  endtask

  // a byte, sometimes preceded by ticks; short timeouts get ticks past the limit
  task automatic send_byte(input logic [7:0] b);
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = (sb.timeout_ms <= 4) ? $urandom_range(1, sb.timeout_ms + 2) : $urandom_range(1, 2);
      repeat (n) send_item(REQ_TICK, 8'($urandom));
    end
    send_item(REQ_BYTE, b);
  endtask

  // one frame with random content; length and end byte good or broken
  task automatic send_frame(input bit len_ok, input bit end_ok);
    int cap;
    int k;
    logic [7:0] len_b;
    cap = (sb.max_len > MAX_DATA_LEN) ? MAX_DATA_LEN : int'(sb.max_len);
    if (len_ok && cap > 0) begin
      len_b = 8'($urandom_range(1, cap));
    end else begin
      case ($urandom_range(0, 2))
        0: len_b = 8'd0;
        1: len_b = 8'($urandom_range(cap + 1, 15));
        default: len_b = 8'($urandom_range(16, 255));
      endcase
    end
    send_byte(sb.start_b);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(len_b);
    if (len_b == 0 || len_b > cap) return;
    for (k = 0; k < len_b; k++) send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(end_ok ? sb.end_b : 8'($urandom));
  endtask

  // apb write, then read back through the same port
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] kept;
    case (idx)
      REG_START, REG_END: mask = 32'h0000_00FF;
      REG_MAX_LEN:        mask = 32'h0000_000F;
      default:            mask = 32'h0000_FFFF;
    endcase
    kept    = val & mask;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom & ~mask) | kept;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, kept);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept)
      sb.report($sformatf("register %0d reads %h, expected %h", idx, prdata, kept));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // stop offering items until every predicted result has come out
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one config setting followed by a mix of frames, noise and tick bursts
  task automatic run_phase(input logic [7:0] st, input logic [7:0] en, input logic [3:0] ml,
                           input logic [15:0] tmo, input int budget, input bit hold);
    int stop_at;
    int r;
    wait_drained();
    cfg_write(REG_START, 32'(st));
    cfg_write(REG_END, 32'(en));
    cfg_write(REG_MAX_LEN, 32'(ml));
    cfg_write(REG_TIMEOUT, 32'(tmo));
    if (hold) rx_hold_req = 1'b1;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 4) == 0) ? sb.start_b : 8'($urandom));
      end else begin
        repeat ((sb.timeout_ms <= 4) ? $urandom_range(1, sb.timeout_ms + 2)
                                     : $urandom_range(1, 4))
          send_item(REQ_TICK, 8'($urandom));
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    logic [7:0] opening [0:22];
    int i;
    sb          = new();
    sent        = 0;
    quiet_tail  = 1'b0;
    rx_hold_req = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = REQ_BYTE;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset config: shortest frame with extreme fields, zero length,
    // oversize length, wrong end byte, then a lone tick
    opening = '{START_RST, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, END_RST,
                START_RST, 8'h12, 8'h34, 8'h00,
                START_RST, 8'h01, 8'h02, 8'hFF,
                START_RST, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h5A, 8'h00};
    for (i = 0; i < 23; i++) send_item(REQ_BYTE, opening[i]);
    send_item(REQ_TICK, 8'($urandom));

    run_phase(8'h00, 8'hFF, 4'd8, 16'hFFFF, 70, 1'b1);
    run_phase(8'hFF, 8'h00, 4'd1, 16'd1, 60, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 4'd3, 16'd2, 60, 1'b0);
    // max_len of zero drops every frame
    run_phase(8'h5A, 8'hA5, 4'd0, 16'd3, 20, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 4'd15, 16'd4, 60, 1'b0);
    quiet_tail = 1'b1;
    run_phase(START_RST, END_RST, MAX_LEN_RST, TIMEOUT_RST, 60, 1'b0);

    wait_drained();
    if (sb.errors == 0)
      $display("** uart_frame_deframer: PASSED **");
    else
      $display("** uart_frame_deframer: FAILED **");
    $finish;
  end

endmodule
